@@ sv/srr_pkg.sv @@
// ----------------------------------------------------------------------------
// srr_pkg: shared constants for the segment reorder release unit
// Default store depth, pixel index width and buffer tag width.
// ----------------------------------------------------------------------------
package srr_pkg;

	localparam int SRR_STORE_DEPTH = 16;
	localparam int SRR_PIXEL_BITS  = 24;
	localparam int SRR_TAG_BITS    = 16;

endpackage

@@ sv/segment_reorder_release_unit.sv @@
// ----------------------------------------------------------------------------
// segment_reorder_release_unit: in-order release of out-of-order segments
// Release order: a matching segment's results come out one per rescan of the
//   store, and the scan restarts from the first entry after each release.
// Occupancy: one segment at a time. A mismatched segment is placed in the
//   first free entry, or dropped when none is free. The single
//   entry compare and the offset adder are walked over the store by index.
// Reset: arst_n clears the expected offset, scene size, valid marks and
//   the sequencer. Stored entry payloads are not cleared.
// ----------------------------------------------------------------------------
module segment_reorder_release_unit
	import srr_pkg::*;
#(
	parameter int STORE_DEPTH = SRR_STORE_DEPTH,
	parameter int PIXEL_BITS  = SRR_PIXEL_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [PIXEL_BITS:0]   cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIXEL_BITS-1:0] seg_offset,
	input  logic [PIXEL_BITS:0]   seg_length,
	input  logic [SRR_TAG_BITS-1:0] seg_tag,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [SRR_TAG_BITS-1:0] out_tag,
	output logic [PIXEL_BITS-1:0] out_offset,
	output logic [PIXEL_BITS:0]   out_length,
	output logic                  scene_done,
	output logic                  dropped,
	output logic                  last_of_run
);

	localparam int IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(STORE_DEPTH - 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_PLACE = 2'd2;
	localparam logic [1:0] S_FLUSH = 2'd3;

	// control state
	logic [1:0]             state_q;
	logic [IW-1:0]          idx_q;
	logic [IW-1:0]          idx_d;
	logic [PIXEL_BITS:0]    expected_q;
	logic [PIXEL_BITS:0]    scene_q;
	logic [STORE_DEPTH-1:0] valid_q;
	logic                   out_valid_q;

	// entry store
	logic [PIXEL_BITS-1:0]   start_mem [STORE_DEPTH];
	logic [PIXEL_BITS:0]     count_mem [STORE_DEPTH];
	logic [SRR_TAG_BITS-1:0] handle_mem [STORE_DEPTH];

	// entry at the scan index, registered from the next scan index
	logic [PIXEL_BITS-1:0]   rd_start_q;
	logic [PIXEL_BITS:0]     rd_count_q;
	logic [SRR_TAG_BITS-1:0] rd_handle_q;

	// held result, presented once its last_of_run is known
	logic [SRR_TAG_BITS-1:0] pend_tag_q;
	logic [PIXEL_BITS-1:0]   pend_offset_q;
	logic [PIXEL_BITS:0]     pend_length_q;
	logic                    pend_done_q;
	logic                    pend_drop_q;

	// output register
	logic [SRR_TAG_BITS-1:0] out_tag_q;
	logic [PIXEL_BITS-1:0]   out_offset_q;
	logic [PIXEL_BITS:0]     out_length_q;
	logic                    out_done_q;
	logic                    out_drop_q;
	logic                    out_last_q;

	logic                    out_free;
	logic                    in_xfer;
	logic                    in_match;
	logic                    hit;
	logic                    scan_release;
	logic                    out_load;
	logic                    out_load_last;
	logic [PIXEL_BITS:0]     add_len;
	logic [PIXEL_BITS+1:0]   add_sum;
	logic [PIXEL_BITS:0]     next_expected;
	logic                    next_done;

	// handshake
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign in_xfer  = in_valid && !in_stall;
	assign in_match = ({1'b0, seg_offset} == expected_q);

	// shared entry compare at the scan index
	assign hit          = valid_q[idx_q] && ({1'b0, rd_start_q} == expected_q);
	assign scan_release = (state_q == S_SCAN) && hit && out_free;

	// shared saturating offset adder
	assign add_len       = (state_q == S_IDLE) ? seg_length : rd_count_q;
	assign add_sum       = {1'b0, expected_q} + {1'b0, add_len};
	assign next_expected = add_sum[PIXEL_BITS+1] ? '1 : add_sum[PIXEL_BITS:0];
	assign next_done     = (next_expected == scene_q);

	// push the held result out: mid-run on a new release, last at flush
	assign out_load_last = (state_q == S_FLUSH) && out_free;
	assign out_load      = scan_release || out_load_last;

	// next scan index: restart on a transfer or a release, else step while scanning or placing
	always_comb begin
		idx_d = idx_q;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					idx_d = '0;
				end
			end
			S_SCAN: begin
				if (hit) begin
					if (out_free) begin
						idx_d = '0;
					end
				end else if (idx_q != LAST_IDX) begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_PLACE: begin
				if (valid_q[idx_q] && idx_q != LAST_IDX) begin
					idx_d = idx_q + 1'b1;
				end
			end
			default: begin
				idx_d = idx_q;
			end
		endcase
	end

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			expected_q  <= '0;
			scene_q     <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			idx_q <= idx_d;
			if (cfg_wr_en) begin
				scene_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (in_match) begin
							expected_q <= next_expected;
							state_q    <= S_SCAN;
						end else begin
							state_q <= S_PLACE;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						if (out_free) begin
							expected_q     <= next_expected;
							valid_q[idx_q] <= 1'b0;
						end
					end else if (idx_q == LAST_IDX) begin
						state_q <= S_FLUSH;
					end
				end
				S_PLACE: begin
					if (!valid_q[idx_q]) begin
						valid_q[idx_q] <= 1'b1;
						state_q        <= S_IDLE;
					end else if (idx_q == LAST_IDX) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// entry store writes and the registered read at the next index
	always_ff @(posedge clk) begin
		if (state_q == S_PLACE && !valid_q[idx_q]) begin
			start_mem[idx_q]  <= pend_offset_q;
			count_mem[idx_q]  <= pend_length_q;
			handle_mem[idx_q] <= pend_tag_q;
		end
		rd_start_q  <= start_mem[idx_d];
		rd_count_q  <= count_mem[idx_d];
		rd_handle_q <= handle_mem[idx_d];
	end

	// held result: capture the input or the released entry
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pend_tag_q    <= seg_tag;
			pend_offset_q <= seg_offset;
			pend_length_q <= seg_length;
			pend_done_q   <= in_match && next_done;
			pend_drop_q   <= !in_match;
		end else if (scan_release) begin
			pend_tag_q    <= rd_handle_q;
			pend_offset_q <= rd_start_q;
			pend_length_q <= rd_count_q;
			pend_done_q   <= next_done;
			pend_drop_q   <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_tag_q    <= pend_tag_q;
			out_offset_q <= pend_offset_q;
			out_length_q <= pend_length_q;
			out_done_q   <= pend_done_q;
			out_drop_q   <= pend_drop_q;
			out_last_q   <= out_load_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_tag     = out_tag_q;
	assign out_offset  = out_offset_q;
	assign out_length  = out_length_q;
	assign scene_done  = out_done_q;
	assign dropped     = out_drop_q;
	assign last_of_run = out_last_q;

endmodule

@@ sv/srr_checker.sv @@
// ----------------------------------------------------------------------------
// srr_checker: port-level checks for the segment reorder release unit
// Watches the handshakes and the result flags; bound to the top level.
// ----------------------------------------------------------------------------
module srr_checker
	import srr_pkg::*;
#(
	parameter int PIXEL_BITS = SRR_PIXEL_BITS
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [SRR_TAG_BITS-1:0] out_tag,
	input logic [PIXEL_BITS-1:0]   out_offset,
	input logic [PIXEL_BITS:0]     out_length,
	input logic                    scene_done,
	input logic                    dropped,
	input logic                    last_of_run
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_tag) &&
		$stable(out_offset) && $stable(out_length) && $stable(last_of_run))
		else $error("stalled result changed");

	// one segment at a time: stall right after an input transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second segment taken while busy");

	// a dropped segment ends its run and never completes the scene
	a_drop_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> last_of_run && !scene_done)
		else $error("dropped result with bad flags");

	// a mid-run result is always a release
	a_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> !dropped)
		else $error("drop inside a release run");

endmodule

bind segment_reorder_release_unit srr_checker #(.PIXEL_BITS(PIXEL_BITS)) u_srr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_tag     (out_tag),
	.out_offset  (out_offset),
	.out_length  (out_length),
	.scene_done  (scene_done),
	.dropped     (dropped),
	.last_of_run (last_of_run)
);

@@ dv/tb_segment_reorder_release_unit.sv @@
// ----------------------------------------------------------------------------
// tb_segment_reorder_release_unit: self-checking bench for the reorder unit
// Feeds segment descriptors in and out of order, predicts every release and
// drop in order, and checks each output transfer against the oldest pending
// release. Covers directed corner cases, random chains and pressure phases.
// ----------------------------------------------------------------------------
module tb_segment_reorder_release_unit;
	import srr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PB             = SRR_PIXEL_BITS;
	localparam int TB             = SRR_TAG_BITS;
	localparam int DEPTH          = SRR_STORE_DEPTH;
	localparam int RAND_ITEMS     = 260;
	localparam int JUMP_PHASE     = 10;
	localparam int PRESSURE_PHASE = 3;
	localparam int LONG_HOLD      = 400;
	localparam int SETTLE_CYCLES  = 2 * DEPTH + 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [PB:0] SCENE_MAX = {1'b1, {PB{1'b0}}};

	typedef logic [PB-1:0] ofs_t;
	typedef logic [PB:0]   len_t;
	typedef logic [TB-1:0] tag_t;

	typedef struct packed {
		logic [PB-1:0] offset;
		logic [PB:0]   length;
		logic [TB-1:0] tag;
	} segment_t;

	typedef struct packed {
		logic [TB-1:0] tag;
		logic [PB-1:0] offset;
		logic [PB:0]   length;
		logic          done;
		logic          drop;
		logic          last;
	} release_t;

	logic          clk         = 1'b0;
	logic          arst_n      = 1'b0;
	logic          cfg_wr_en   = 1'b0;
	logic [PB:0]   cfg_wr_data = '0;
	logic          in_valid    = 1'b0;
	logic          in_stall;
	logic [PB-1:0] seg_offset  = '0;
	logic [PB:0]   seg_length  = '0;
	logic [TB-1:0] seg_tag     = '0;
	logic          out_valid;
	logic          out_stall   = 1'b0;
	logic [TB-1:0] out_tag;
	logic [PB-1:0] out_offset;
	logic [PB:0]   out_length;
	logic          scene_done;
	logic          dropped;
	logic          last_of_run;

	// predictor state: expected offset, scene size and the segment store
	logic [PB:0]   next_ofs = '0;
	logic [PB:0]   scene_px = '0;
	logic          slot_used  [DEPTH];
	logic [PB-1:0] slot_start [DEPTH];
	logic [PB:0]   slot_len   [DEPTH];
	logic [TB-1:0] slot_tag   [DEPTH];

	segment_t segment_queue[$];
	release_t pending_releases[$];

	segment_t cur_seg;
	release_t want_rel;
	logic     tx_valid_nxt;
	int       tx_gap        = 0;
	bit       no_gaps       = 1'b0;
	bit       rx_free       = 1'b0;
	bit       long_hold_req = 1'b0;
	logic     rx_stalling   = 1'b0;
	int       rx_left       = 0;
	int       quiet_cycles  = 0;

	int seg_queued    = 0;
	int seg_accepted  = 0;
	int releases_seen = 0;
	int drops_seen    = 0;
	int done_seen     = 0;
	int scene_writes  = 0;
	int errors        = 0;

	segment_reorder_release_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.seg_offset  (seg_offset),
		.seg_length  (seg_length),
		.seg_tag     (seg_tag),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_tag     (out_tag),
		.out_offset  (out_offset),
		.out_length  (out_length),
		.scene_done  (scene_done),
		.dropped     (dropped),
		.last_of_run (last_of_run)
	);

	always #1 clk = ~clk;

	initial begin
		for (int i = 0; i < DEPTH; i++) begin
			slot_used[i] = 1'b0;
		end
	end

	// Advance an offset, saturating at all ones on carry out of the top bit
	function automatic logic [PB:0] advance_offset(input logic [PB:0] base,
			input logic [PB:0] len);
		logic [PB+1:0] sum;
		sum = {1'b0, base} + {1'b0, len};
		return sum[PB+1] ? '1 : sum[PB:0];
	endfunction

	// Idle length for either side: mostly none or short, a few long
	function automatic int rand_pause();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 88) return $urandom_range(1, 3);
		if (p < 98) return $urandom_range(4, 20);
		return $urandom_range(30, 90);
	endfunction

	function automatic logic [PB:0] random_length();
		int p;
		p = $urandom_range(0, 99);
		if (p < 10) return '0;
		if (p < 15) return len_t'($urandom_range(2000, 60000));
		return len_t'($urandom_range(1, 2000));
	endfunction

	function automatic logic [TB-1:0] rand_tag();
		return tag_t'($urandom_range(0, 16'hFFFF));
	endfunction

	// Predict the releases caused by one accepted segment
	task automatic reorder_segment(input segment_t seg);
		release_t rel;
		logic     hit;
		if ({1'b0, seg.offset} != next_ofs) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (!slot_used[i]) begin
					slot_used[i]  = 1'b1;
					slot_start[i] = seg.offset;
					slot_len[i]   = seg.length;
					slot_tag[i]   = seg.tag;
					return;
				end
			end
			rel = '{tag: seg.tag, offset: seg.offset, length: seg.length,
				done: 1'b0, drop: 1'b1, last: 1'b1};
			pending_releases.push_back(rel);
			return;
		end
		next_ofs = advance_offset(next_ofs, seg.length);
		rel = '{tag: seg.tag, offset: seg.offset, length: seg.length,
			done: (next_ofs == scene_px), drop: 1'b0, last: 1'b0};
		// rescan the store until no entry starts at the expected offset
		do begin
			hit = 1'b0;
			for (int i = 0; i < DEPTH; i++) begin
				if (!hit && slot_used[i] && {1'b0, slot_start[i]} == next_ofs) begin
					hit          = 1'b1;
					slot_used[i] = 1'b0;
					next_ofs     = advance_offset(next_ofs, slot_len[i]);
					pending_releases.push_back(rel);
					rel = '{tag: slot_tag[i], offset: slot_start[i], length: slot_len[i],
						done: (next_ofs == scene_px), drop: 1'b0, last: 1'b0};
				end
			end
		end while (hit);
		rel.last = 1'b1;
		pending_releases.push_back(rel);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	task automatic send_seg(input logic [PB-1:0] ofs, input logic [PB:0] len,
			input logic [TB-1:0] tag);
		segment_queue.push_back('{offset: ofs, length: len, tag: tag});
		seg_queued++;
	endtask

	// Wait until every segment is taken and every release has come out
	task automatic wait_idle();
		while (seg_accepted != seg_queued || pending_releases.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_scene(input logic [PB:0] value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		scene_px = value;
		scene_writes++;
	endtask

	// Close the gap to nearby stored entries left by broken chains
	task automatic bridge_stored();
		logic [PB:0] nearest;
		bit          found;
		repeat (4) begin
			found   = 1'b0;
			nearest = '1;
			for (int i = 0; i < DEPTH; i++) begin
				if (slot_used[i] && {1'b0, slot_start[i]} > next_ofs &&
						{1'b0, slot_start[i]} - next_ofs <= len_t'(1 << 20) &&
						{1'b0, slot_start[i]} < nearest) begin
					nearest = {1'b0, slot_start[i]};
					found   = 1'b1;
				end
			end
			if (found) begin
				send_seg(next_ofs[PB-1:0], nearest - next_ofs, rand_tag());
				wait_idle();
			end
		end
	endtask

	// One random phase: a contiguous chain from the expected offset, sent in
	// some order, sometimes with a piece missing or a stray segment mixed in
	task automatic run_phase(input int phase);
		logic [PB:0]   lens  [16];
		logic [PB:0]   starts[16];
		logic [TB-1:0] tags  [16];
		int            order [16];
		int            n, occ, j, tmp, skip, noise_at, pick;
		logic [PB:0]   end_ofs;
		bit            pressure;
		pressure = (phase == PRESSURE_PHASE);
		bridge_stored();
		occ = 0;
		for (int i = 0; i < DEPTH; i++) begin
			occ += int'(slot_used[i]);
		end
		n = (DEPTH - occ > 14) ? 14 : DEPTH - occ;
		if (n < 1) n = 1;
		n = pressure ? 14 : $urandom_range(1, n);
		end_ofs = next_ofs;
		for (int i = 0; i < n; i++) begin
			starts[i] = end_ofs;
			if (phase == JUMP_PHASE && i == 0 && next_ofs < len_t'(1 << 22))
				lens[i] = len_t'($urandom_range(1 << 23, (1 << 23) + (1 << 20)));
			else
				lens[i] = random_length();
			tags[i]  = rand_tag();
			end_ofs  = advance_offset(end_ofs, lens[i]);
			order[i] = i;
		end
		pick = pressure ? 0 : $urandom_range(0, 3);
		if (pick == 1) begin
			for (int i = 0; i < n; i++) begin
				order[i] = n - 1 - i;
			end
		end else if (pick >= 2) begin
			for (int i = n - 1; i > 0; i--) begin
				j        = $urandom_range(0, i);
				tmp      = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
		end
		skip = -1;
		if (!pressure && phase != JUMP_PHASE && n >= 3 && $urandom_range(0, 4) == 0)
			skip = $urandom_range(1, n - 1);
		noise_at = -1;
		if (!pressure && occ <= 3 && $urandom_range(0, 3) == 0)
			noise_at = $urandom_range(0, n - 1);
		pick = $urandom_range(0, 19);
		if (pick < 10)
			write_scene(end_ofs);
		else if (pick < 13)
			write_scene(len_t'($urandom_range(0, 1 << 24)));
		else if (pick < 15)
			write_scene('0);
		else if (pick < 16)
			write_scene(SCENE_MAX);
		no_gaps = pressure || ($urandom_range(0, 6) == 0);
		rx_free = !pressure && no_gaps;
		if (pressure) long_hold_req = 1'b1;
		for (int i = 0; i < n; i++) begin
			if (i == noise_at)
				send_seg(ofs_t'($urandom_range(0, 24'hFFFFFF)),
					len_t'($urandom_range(1, 65535)), rand_tag());
			if (order[i] != skip)
				send_seg(starts[order[i]][PB-1:0], lens[order[i]], tags[order[i]]);
		end
		wait_idle();
		no_gaps = 1'b0;
		rx_free = 1'b0;
	endtask

	// Drive segments: hold the payload while stalled, load the next after a gap
	always @(posedge clk) begin
		if (arst_n) begin
			tx_valid_nxt = in_valid;
			if (in_valid && !in_stall) begin
				reorder_segment(cur_seg);
				seg_accepted++;
				tx_valid_nxt = 1'b0;
				tx_gap = no_gaps ? 0 : rand_pause();
			end
			if (!tx_valid_nxt) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (segment_queue.size() > 0) begin
					cur_seg      = segment_queue.pop_front();
					seg_offset   <= cur_seg.offset;
					seg_length   <= cur_seg.length;
					seg_tag      <= cur_seg.tag;
					tx_valid_nxt = 1'b1;
				end
			end
			in_valid <= tx_valid_nxt;
		end
	end

	// Check each output transfer and pick the next receiver stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_releases.size() == 0) begin
					$error("release with none pending: tag 0x%0h offset 0x%0h",
						out_tag, out_offset);
					errors++;
				end else begin
					want_rel = pending_releases.pop_front();
					check_field("out_tag", 32'(want_rel.tag), 32'(out_tag));
					check_field("out_offset", 32'(want_rel.offset), 32'(out_offset));
					check_field("out_length", 32'(want_rel.length), 32'(out_length));
					check_field("scene_done", 32'(want_rel.done), 32'(scene_done));
					check_field("dropped", 32'(want_rel.drop), 32'(dropped));
					check_field("last_of_run", 32'(want_rel.last), 32'(last_of_run));
				end
				releases_seen++;
				if (dropped) drops_seen++;
				if (scene_done) done_seen++;
			end
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				rx_stalling   = 1'b1;
				rx_left       = LONG_HOLD;
			end else if (rx_left > 0) begin
				rx_left--;
			end else if (rx_free || rx_stalling) begin
				rx_stalling = 1'b0;
				rx_left     = $urandom_range(1, 40);
			end else begin
				rx_left     = rand_pause();
				rx_stalling = (rx_left > 0);
			end
			out_stall <= rx_stalling;
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [PB:0] chain_len[17];
		logic [PB:0] chain_ofs[17];
		logic [PB:0] chain_end;
		int          rand_base;
		int          phase;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// zero length at offset zero completes a scene of size zero
		write_scene('0);
		send_seg('0, '0, 16'h0000);
		wait_idle();

		// three pieces in reverse order, the last one released completes the scene
		write_scene(len_t'(100));
		send_seg(ofs_t'(30), len_t'(70), rand_tag());
		send_seg(ofs_t'(10), len_t'(20), rand_tag());
		send_seg(ofs_t'(0), len_t'(10), rand_tag());
		wait_idle();

		// two stored entries with the same start: lower slot goes first
		send_seg(ofs_t'(105), len_t'(0), rand_tag());
		send_seg(ofs_t'(105), len_t'(7), rand_tag());
		send_seg(ofs_t'(100), len_t'(5), rand_tag());
		wait_idle();

		// fill the store, drop one with all-ones fields, then release all 17
		chain_end = next_ofs;
		for (int i = 0; i < 17; i++) begin
			chain_ofs[i] = chain_end;
			chain_len[i] = len_t'($urandom_range(1, 8));
			chain_end    = chain_end + chain_len[i];
		end
		write_scene(chain_end);
		for (int i = 16; i > 0; i--) begin
			send_seg(chain_ofs[i][PB-1:0], chain_len[i], rand_tag());
		end
		send_seg('1, '1, 16'hFFFF);
		send_seg(chain_ofs[0][PB-1:0], chain_len[0], rand_tag());
		wait_idle();

		// stale offset below the expected one is simply stored
		send_seg(next_ofs[PB-1:0] - ofs_t'(50), len_t'(3), rand_tag());
		wait_idle();

		rand_base = seg_queued;
		phase     = 0;
		while (seg_queued - rand_base < RAND_ITEMS) begin
			run_phase(phase);
			phase++;
		end

		// saturate the expected offset, then everything is stored or dropped
		write_scene(SCENE_MAX);
		send_seg(next_ofs[PB-1:0], '1, 16'hFFFF);
		repeat (30) begin
			send_seg(ofs_t'($urandom_range(0, 24'hFFFFFF)),
				len_t'($urandom_range(0, 25'h1FFFFFF)), rand_tag());
		end
		wait_idle();

		$display("Run: %0d segments, %0d releases (%0d dropped, %0d scene completions)",
			seg_accepted, releases_seen, drops_seen, done_seen);
		$display("Run: %0d scene size writes over %0d random phases", scene_writes, phase);
		if (errors == 0 && pending_releases.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
